@@ rtl/rfga_pkg.sv @@
// Package for the radial falloff grid accumulate unit.
// Holds register indexes, widths, the controller state type and the command/status structs.
// No dependencies.
package rfga_pkg;

  localparam int unsigned GridDimDefault = 4096;
  localparam int unsigned CountW = 25;
  localparam int unsigned IndexW = 3;

  localparam logic [IndexW-1:0] RegCenterX   = 3'd0;
  localparam logic [IndexW-1:0] RegCenterY   = 3'd1;
  localparam logic [IndexW-1:0] RegInnerRad  = 3'd2;
  localparam logic [IndexW-1:0] RegOuterRad  = 3'd3;
  localparam logic [IndexW-1:0] RegInnerVal  = 3'd4;
  localparam logic [IndexW-1:0] RegOuterVal  = 3'd5;
  localparam logic [IndexW-1:0] RegOuterIncl = 3'd6;

  // Root: 42-bit radicand gives 21 result bits. Divide: 54-bit quotient.
  localparam int unsigned SqrtSteps = 21;
  localparam int unsigned DivSteps  = 54;

  typedef enum logic [2:0] {
    StIdle, StDist, StSqrt, StMul, StDiv, StSum, StOut
  } rfga_state_e;

  typedef struct packed {
    logic load;       // capture the request and start the distance
    logic sqrt_init;
    logic sqrt_step;
    logic mul;
    logic div_init;
    logic div_step;
    logic sum;        // form the final value and update the count
  } rfga_cmd_t;

  typedef struct packed {
    logic need_interp; // cell lies between the radii
  } rfga_stat_t;

endpackage

@@ rtl/rfga_ctrl.sv @@
// Controller state machine of the radial falloff grid accumulate unit.
// Depends on rfga_pkg; drives commands into rfga_datapath.
module rfga_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic                out_ready_i,
  output logic                out_valid_o,
  input  rfga_pkg::rfga_stat_t stat_i,
  output rfga_pkg::rfga_cmd_t  cmd_o
);
  import rfga_pkg::*;

  rfga_state_e state_q, state_d;
  logic [5:0] cnt_q, cnt_d;

  // Next state.
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    case (state_q)
      StIdle: if (in_valid_i) state_d = StDist;
      StDist: begin
        if (stat_i.need_interp) begin
          state_d = StSqrt;
          cnt_d   = '0;
        end else begin
          state_d = StSum;
        end
      end
      StSqrt: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(SqrtSteps - 1)) state_d = StMul;
      end
      StMul: begin
        state_d = StDiv;
        cnt_d   = '0;
      end
      StDiv: begin
        cnt_d = cnt_q + 6'd1;
        if (cnt_q == 6'(DivSteps - 1)) state_d = StSum;
      end
      StSum: state_d = StOut;
      StOut: if (out_ready_i) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o = '0;
    in_ready_o  = (state_q == StIdle);
    out_valid_o = (state_q == StOut);
    case (state_q)
      StIdle: cmd_o.load = in_valid_i;
      StDist: cmd_o.sqrt_init = stat_i.need_interp;
      StSqrt: cmd_o.sqrt_step = 1'b1;
      StMul:  cmd_o.mul = 1'b1;
      StDiv:  begin
        cmd_o.div_step = 1'b1;
        cmd_o.div_init = (cnt_q == '0);
      end
      StSum:  cmd_o.sum = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

@@ rtl/rfga_datapath.sv @@
// Datapath of the radial falloff grid accumulate unit: config registers,
// squared distance, bit-serial square root, restoring divider, count. Uses rfga_pkg.
module rfga_datapath #(
  parameter int unsigned GridDim = rfga_pkg::GridDimDefault
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  input  logic [rfga_pkg::IndexW-1:0]        cfg_index_i,
  input  logic [31:0]                        cfg_data_i,
  input  logic [11:0]                        cell_x_i,
  input  logic [11:0]                        cell_y_i,
  input  logic signed [31:0]                 cell_value_i,
  input  logic                               last_cell_i,
  input  rfga_pkg::rfga_cmd_t                cmd_i,
  output rfga_pkg::rfga_stat_t               stat_o,
  output logic signed [31:0]                 new_value_o,
  output logic                               cell_touched_o,
  output logic                               spec_status_o,
  output logic [rfga_pkg::CountW-1:0]        touched_total_o,
  output logic                               pass_done_o
);
  import rfga_pkg::*;

  // Configuration registers.
  logic signed [20:0] cx_q, cy_q;
  logic [19:0] ir_q, or_q;
  logic signed [31:0] iv_q, ov_q;
  logic incl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q <= '0; cy_q <= '0; ir_q <= '0; or_q <= '0;
      iv_q <= '0; ov_q <= '0; incl_q <= 1'b1;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegCenterX:   cx_q <= cfg_data_i[20:0];
        RegCenterY:   cy_q <= cfg_data_i[20:0];
        RegInnerRad:  ir_q <= cfg_data_i[19:0];
        RegOuterRad:  or_q <= cfg_data_i[19:0];
        RegInnerVal:  iv_q <= cfg_data_i;
        RegOuterVal:  ov_q <= cfg_data_i;
        RegOuterIncl: incl_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Request capture and offsets from the center (Q.8, 22-bit signed).
  logic signed [31:0] val_q;
  logic last_q, ongrid_q;
  logic signed [21:0] dx_q, dy_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q    <= cell_value_i;
      last_q   <= last_cell_i;
      ongrid_q <= (32'(cell_x_i) < 32'(GridDim)) && (32'(cell_y_i) < 32'(GridDim));
      dx_q     <= $signed({2'b00, cell_x_i, 8'h00}) - 22'(cx_q);
      dy_q     <= $signed({2'b00, cell_y_i, 8'h00}) - 22'(cy_q);
    end
  end

  // Squared distance and radius tests.
  logic [43:0] dxx, dyy;
  logic [43:0] d2;
  logic [39:0] o2, i2;
  logic bad, in_reach, inner_hit;
  assign dxx = 44'(dx_q) * 44'(dx_q);
  assign dyy = 44'(dy_q) * 44'(dy_q);
  assign d2  = dxx + dyy;
  assign o2  = or_q * or_q;
  assign i2  = ir_q * ir_q;
  assign bad = or_q < ir_q;
  assign in_reach = incl_q ? (d2 <= 44'(o2)) : (d2 < 44'(o2));
  assign inner_hit = (d2 <= 44'(i2)) || (or_q == ir_q);

  logic touch_q, inner_q, bad_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init || (!cmd_i.load && !cmd_i.sqrt_step && !cmd_i.mul &&
        !cmd_i.div_step && !cmd_i.sum && !cmd_i.div_init)) begin
      bad_q   <= bad;
      touch_q <= !bad && ongrid_q && in_reach;
      inner_q <= inner_hit;
    end
  end
  assign stat_o.need_interp = !bad && ongrid_q && in_reach && !inner_hit;

  // Bit-serial square root, two radicand bits per step. A cell between the
  // radii has d2 below 2^40, so the low 42 bits are aligned to the top.
  logic [43:0] rem_q, rad_q;
  logic [21:0] root_q;
  logic [43:0] trial, rem_sh;
  assign rem_sh = {rem_q[41:0], rad_q[43:42]};
  assign trial  = {20'd0, root_q, 2'b01};
  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      rem_q <= '0; rad_q <= {d2[41:0], 2'b00}; root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      rad_q <= {rad_q[41:0], 2'b00};
      if (rem_sh >= trial) begin
        rem_q  <= rem_sh - trial;
        root_q <= {root_q[20:0], 1'b1};
      end else begin
        rem_q  <= rem_sh;
        root_q <= {root_q[20:0], 1'b0};
      end
    end
  end

  // Product (outer - inner value) * (dist - inner radius).
  logic signed [32:0] dv;
  logic [21:0] dd;
  logic signed [55:0] prod_q;
  assign dv = 33'(ov_q) - 33'(iv_q);
  assign dd = root_q - 22'(ir_q);
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) prod_q <= 56'(dv) * 56'($signed({1'b0, dd}));
  end

  // Restoring divider of |prod| by span, one quotient bit per step.
  logic [53:0] dq_q;
  logic [20:0] drem_q;
  logic neg_q;
  logic [53:0] mag;
  logic [53:0] dnum;
  logic [20:0] drem_sh, span;
  logic [21:0] dsub;
  assign span = {1'b0, or_q - ir_q};
  assign mag  = prod_q[55] ? 54'(-prod_q) : prod_q[53:0];
  assign dnum = cmd_i.div_init ? mag : dq_q;
  assign drem_sh = cmd_i.div_init ? 21'd0 : drem_q;
  assign dsub = {drem_sh, dnum[53]} - {1'b0, span};
  always_ff @(posedge clk_i) begin
    if (cmd_i.div_step) begin
      if (cmd_i.div_init) neg_q <= prod_q[55];
      if (!dsub[21]) begin
        drem_q <= dsub[20:0];
        dq_q   <= {dnum[52:0], 1'b1};
      end else begin
        drem_q <= {drem_sh[19:0], dnum[53]};
        dq_q   <= {dnum[52:0], 1'b0};
      end
    end
  end

  // Final value, saturating sum and touched count.
  logic signed [34:0] quo, add, sum;
  logic [CountW-1:0] cnt_q, cnt_now;
  assign quo = neg_q ? -35'(dq_q[33:0]) : 35'(dq_q[33:0]);
  assign add = inner_q ? 35'(iv_q) : 35'(iv_q) + quo;
  assign sum = 35'(val_q) + add;
  assign cnt_now = (touch_q && cnt_q != '1) ? cnt_q + 1'b1 : cnt_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.sum) begin
      if (!touch_q) new_value_o <= val_q;
      else if (sum > 35'sd2147483647) new_value_o <= 32'h7FFFFFFF;
      else if (sum < -35'sd2147483648) new_value_o <= 32'h80000000;
      else new_value_o <= sum[31:0];
      cell_touched_o  <= touch_q;
      spec_status_o   <= bad_q;
      touched_total_o <= cnt_now;
      pass_done_o     <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) cnt_q <= '0;
    else if (cmd_i.sum) cnt_q <= last_q ? '0 : cnt_now;
  end

endmodule

@@ rtl/radial_falloff_grid_accumulate_unit.sv @@
// Top level of the radial falloff grid accumulate unit.
// Joins rfga_ctrl and rfga_datapath; uses rfga_pkg.
//
//  channel   | direction | payload
//  s_axis    | in        | tdata {cell_value, cell_y, cell_x}, tlast last_cell
//  m_axis    | out       | tdata {touched_total, spec_status, cell_touched, new_value}, tlast
//  cfg       | in        | cfg_index selects the register, cfg_data the value
//
// A cell inside the disc or outside goes through the distance, sum and output states; a cell
// between the radii also passes the 21-step square root, the multiply and the 54-step divider.
// Reset clears the config registers and the count; outer_inclusive resets to 1.
// One request is in work at a time; a stalled result holds until taken.
module radial_falloff_grid_accumulate_unit #(
  parameter int unsigned GridDim = rfga_pkg::GridDimDefault
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_valid_i,
  output logic                        cfg_ready_o,
  input  logic [rfga_pkg::IndexW-1:0] cfg_index_i,
  input  logic [31:0]                 cfg_data_i,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [55:0]                 s_axis_tdata,  // cell_x, cell_y, cell_value
  input  logic                        s_axis_tlast,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [63:0]                 m_axis_tdata,  // new_value, cell_touched, spec_status,
                                                     // touched_total, zero fill
  output logic                        m_axis_tlast
);
  import rfga_pkg::*;

  rfga_cmd_t  cmd;
  rfga_stat_t stat;
  logic signed [31:0] new_value;
  logic touched, status, done;
  logic [CountW-1:0] total;

  assign cfg_ready_o = 1'b1;

  rfga_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .out_ready_i(m_axis_tready), .out_valid_o(m_axis_tvalid),
    .stat_i(stat), .cmd_o(cmd)
  );

  rfga_datapath #(.GridDim(GridDim)) u_dp (
    .clk_i, .rst_ni,
    .cfg_valid_i, .cfg_index_i, .cfg_data_i,
    .cell_x_i(s_axis_tdata[11:0]), .cell_y_i(s_axis_tdata[23:12]),
    .cell_value_i(s_axis_tdata[55:24]), .last_cell_i(s_axis_tlast),
    .cmd_i(cmd), .stat_o(stat),
    .new_value_o(new_value), .cell_touched_o(touched), .spec_status_o(status),
    .touched_total_o(total), .pass_done_o(done)
  );

  assign m_axis_tdata = {5'd0, total, status, touched, new_value};
  assign m_axis_tlast = done;

endmodule
